FILE: design/lls_pkg.sv
// Shared types and constants for the least-load server dispatcher.
// No dependencies; every other design file imports this package.
`default_nettype none

package lls_pkg;

    localparam int NUM_SERVERS = 8;
    localparam int COUNT_WIDTH = 16;

    // Fixed field widths of the request, response and register map
    localparam int IDX_W      = 3;
    localparam int CNT_OUT_W  = 16;
    localparam int SCNT_W     = 4;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam int SRV_W   = (NUM_SERVERS > 1) ? $clog2(NUM_SERVERS) : 1;
    localparam int TREE_P  = 1 << SRV_W;
    localparam int NCNT_W  = $clog2(NUM_SERVERS + 1);
    localparam int EFF_W   = (NCNT_W > SCNT_W) ? NCNT_W : SCNT_W;

    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

    typedef enum logic
    {
        OP_DISPATCH = 1'b0,
        OP_RELEASE  = 1'b1
    } opcode_t;

    typedef enum logic [1:0]
    {
        ST_OK      = 2'd0,
        ST_NONE    = 2'd1,
        ST_UNKNOWN = 2'd2
    } status_t;

    typedef enum logic
    {
        REG_MODE         = 1'b0,
        REG_SERVER_COUNT = 1'b1
    } cfg_reg_t;

    typedef enum logic
    {
        MODE_ROUND_ROBIN = 1'b0,
        MODE_LEAST_LOAD  = 1'b1
    } mode_t;

    typedef struct packed
    {
        opcode_t          opcode;
        logic [IDX_W-1:0] server_index;
    } req_item_t;

    typedef struct packed
    {
        status_t              status;
        logic [IDX_W-1:0]     chosen_server;
        logic [CNT_OUT_W-1:0] active_count;
    } rsp_item_t;

    // Configuration as seen by the datapath: server count already clamped
    typedef struct packed
    {
        mode_t            mode;
        logic [EFF_W-1:0] n_active;
    } cfg_t;

    // State write-back produced for one item
    typedef struct packed
    {
        logic                   cnt_wr;
        logic [SRV_W-1:0]       cnt_idx;
        logic [COUNT_WIDTH-1:0] cnt_val;
        logic                   rr_wr;
        logic [SRV_W-1:0]       rr_val;
    } upd_t;

    typedef logic [NUM_SERVERS-1:0][COUNT_WIDTH-1:0] count_arr_t;

endpackage : lls_pkg

`default_nettype wire

FILE: design/lls_cfg.sv
// APB-style register block: mode and server_count.
// Depends on lls_pkg; presents the clamped server count to the datapath.
`default_nettype none

module lls_cfg
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [lls_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [lls_pkg::APB_DATA_W-1:0] pwdata,
    output logic      [lls_pkg::APB_DATA_W-1:0] prdata,
    output logic                                pready,
    output lls_pkg::cfg_t                       cfg
);
    import lls_pkg::*;

    mode_t             mode_reg;
    logic [SCNT_W-1:0] server_count_reg;
    logic              wr_en;
    cfg_reg_t          reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_sel = cfg_reg_t'(paddr[2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg         <= MODE_LEAST_LOAD;
            server_count_reg <= '0;
        end
        else if (wr_en)
        begin
            unique case (reg_sel)
                REG_MODE:         mode_reg         <= mode_t'(pwdata[0]);
                REG_SERVER_COUNT: server_count_reg <= pwdata[SCNT_W-1:0];
                default:          mode_reg         <= mode_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            REG_MODE:         prdata = APB_DATA_W'(mode_reg);
            REG_SERVER_COUNT: prdata = APB_DATA_W'(server_count_reg);
            default:          prdata = '0;
        endcase
    end

    // Counts above the number of physical servers act as the full set
    always_comb
    begin
        cfg.mode = mode_reg;
        if (EFF_W'(server_count_reg) > EFF_W'(NUM_SERVERS))
            cfg.n_active = EFF_W'(NUM_SERVERS);
        else
            cfg.n_active = EFF_W'(server_count_reg);
    end

endmodule : lls_cfg

`default_nettype wire

FILE: design/lls_engine.sv
// Per-item datapath: server choice (round robin or minimum tree), count update.
// Depends on lls_pkg; purely combinational, driven from the request register.
`default_nettype none

module lls_engine
(
    input  wire lls_pkg::cfg_t              cfg,
    input  wire lls_pkg::req_item_t         req,
    input  wire lls_pkg::count_arr_t        counts,
    input  wire logic [lls_pkg::SRV_W-1:0]  rr_ptr,
    output lls_pkg::rsp_item_t              rsp,
    output lls_pkg::upd_t                   upd
);
    import lls_pkg::*;

    // Heap-ordered minimum tree; key MSB marks servers outside the active set
    logic [COUNT_WIDTH:0]   node_key [2*TREE_P-1];
    logic [SRV_W-1:0]       node_idx [2*TREE_P-1];
    logic [SRV_W-1:0]       rr_sel;
    logic [SRV_W-1:0]       rr_inc;
    logic [SRV_W-1:0]       sel;
    logic [SRV_W-1:0]       rel_idx;
    logic [COUNT_WIDTH-1:0] sel_cnt;
    logic [COUNT_WIDTH-1:0] rel_cnt;
    logic [COUNT_WIDTH-1:0] inc_cnt;
    logic [COUNT_WIDTH-1:0] dec_cnt;
    logic                   rel_known;

    always_comb
    begin
        for (int i = 0; i < TREE_P; i++)
        begin
            node_idx[TREE_P-1+i] = SRV_W'(i);
            if (i < NUM_SERVERS && EFF_W'(i) < cfg.n_active)
                node_key[TREE_P-1+i] = {1'b0, counts[i]};
            else
                node_key[TREE_P-1+i] = '1;
        end
        // Right child wins only when strictly smaller: ties keep the lower index
        for (int k = TREE_P - 2; k >= 0; k--)
        begin
            if (node_key[2*k+2] < node_key[2*k+1])
            begin
                node_key[k] = node_key[2*k+2];
                node_idx[k] = node_idx[2*k+2];
            end
            else
            begin
                node_key[k] = node_key[2*k+1];
                node_idx[k] = node_idx[2*k+1];
            end
        end
    end

    always_comb
    begin
        // Stale pointer restarts at server 0
        if (EFF_W'(rr_ptr) < cfg.n_active)
            rr_sel = rr_ptr;
        else
            rr_sel = '0;
        if (EFF_W'(rr_sel) + EFF_W'(1) >= cfg.n_active)
            rr_inc = '0;
        else
            rr_inc = rr_sel + SRV_W'(1);
    end

    assign sel       = (cfg.mode == MODE_ROUND_ROBIN) ? rr_sel : node_idx[0];
    assign rel_idx   = SRV_W'(req.server_index);
    assign rel_known = (EFF_W'(req.server_index) < cfg.n_active);
    assign sel_cnt   = counts[sel];
    assign rel_cnt   = counts[rel_idx];
    assign inc_cnt   = (sel_cnt == COUNT_MAX) ? sel_cnt : sel_cnt + COUNT_WIDTH'(1);
    assign dec_cnt   = (rel_cnt == '0) ? rel_cnt : rel_cnt - COUNT_WIDTH'(1);

    always_comb
    begin
        rsp.status        = ST_OK;
        rsp.chosen_server = '0;
        rsp.active_count  = '0;
        upd.cnt_wr        = 1'b0;
        upd.cnt_idx       = sel;
        upd.cnt_val       = inc_cnt;
        upd.rr_wr         = 1'b0;
        upd.rr_val        = rr_inc;

        unique case (req.opcode)
            OP_DISPATCH:
            begin
                if (cfg.n_active == '0)
                    rsp.status = ST_NONE;
                else
                begin
                    rsp.chosen_server = IDX_W'(sel);
                    rsp.active_count  = CNT_OUT_W'(inc_cnt);
                    upd.cnt_wr        = 1'b1;
                    upd.rr_wr         = (cfg.mode == MODE_ROUND_ROBIN);
                end
            end
            OP_RELEASE:
            begin
                rsp.chosen_server = req.server_index;
                if (!rel_known)
                    rsp.status = ST_UNKNOWN;
                else
                begin
                    rsp.active_count = CNT_OUT_W'(dec_cnt);
                    upd.cnt_wr       = 1'b1;
                    upd.cnt_idx      = rel_idx;
                    upd.cnt_val      = dec_cnt;
                end
            end
            default:
            begin
                rsp.status = ST_OK;
            end
        endcase
    end

endmodule : lls_engine

`default_nettype wire

FILE: design/least_load_server_dispatcher_core.sv
// Top level of the least-load / round-robin server dispatcher.
// Depends on lls_pkg, lls_cfg and lls_engine.
//
//   channel   | direction | handshake           | payload
//   ----------+-----------+---------------------+-------------------------
//   req       | in        | req_valid/req_ready | opcode, server_index
//   rsp       | out       | rsp_valid/rsp_ready | status, server, count
//   apb       | in        | psel/penable/pready | mode, server_count
//
// One item per cycle sustained while results are taken. An item is
// registered on acceptance, goes through the selection logic from the request
// register and its result is registered once the result slot is free. The
// per-cycle path is the server minimum tree plus the count increment. Reset
// clears all counts and the round-robin pointer at once. A stalled result
// holds the request register, and ready drops only when both are full and
// the result is not taken.
`default_nettype none

module least_load_server_dispatcher_core
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           req_valid,
    output logic                                req_ready,
    input  wire lls_pkg::req_item_t             req,
    output logic                                rsp_valid,
    input  wire logic                           rsp_ready,
    output lls_pkg::rsp_item_t                  rsp,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [lls_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [lls_pkg::APB_DATA_W-1:0] pwdata,
    output logic      [lls_pkg::APB_DATA_W-1:0] prdata,
    output logic                                pready
);
    import lls_pkg::*;

    cfg_t             cfg;
    logic             req_vld_reg;
    req_item_t        req_reg;
    logic             rsp_vld_reg;
    rsp_item_t        rsp_reg;
    count_arr_t       counts_reg;
    logic [SRV_W-1:0] rr_reg;
    rsp_item_t        rsp_next;
    upd_t             upd;
    logic             fire;

    lls_cfg u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    lls_engine u_engine
    (
        .cfg    (cfg),
        .req    (req_reg),
        .counts (counts_reg),
        .rr_ptr (rr_reg),
        .rsp    (rsp_next),
        .upd    (upd)
    );

    // The item in the request register is processed when the result slot frees
    assign fire      = req_vld_reg & (~rsp_vld_reg | rsp_ready);
    assign req_ready = ~req_vld_reg | fire;
    assign rsp_valid = rsp_vld_reg;
    assign rsp       = rsp_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_vld_reg <= 1'b0;
            rsp_vld_reg <= 1'b0;
            rr_reg      <= '0;
            counts_reg  <= '0;
        end
        else
        begin
            if (req_ready)
                req_vld_reg <= req_valid;
            if (fire)
                rsp_vld_reg <= 1'b1;
            else if (rsp_ready)
                rsp_vld_reg <= 1'b0;
            if (fire && upd.cnt_wr)
                counts_reg[upd.cnt_idx] <= upd.cnt_val;
            if (fire && upd.rr_wr)
                rr_reg <= upd.rr_val;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_ready && req_valid)
            req_reg <= req;
        if (fire)
            rsp_reg <= rsp_next;
    end

endmodule : least_load_server_dispatcher_core

`default_nettype wire
